[src/lfu_pkg.sv]
// Shared types and constants for the LFU table with time tiebreak.
// Holds the scan beat and update command structs used by the cells and the top level.
// No dependencies.
package lfu_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int SLOTS_MAX = 256;
  localparam int IDX_W     = $clog2(SLOTS_MAX);
  localparam int USED_W    = $clog2(SLOTS_MAX + 1);

  localparam int KEY_W  = 32;
  localparam int TIME_W = 32;
  localparam int CNT_W  = 16;
  localparam int CAP_W  = 5;
  localparam int FUNC_W = 2;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;

  // Register index, taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_USE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INSERT,
    CMD_USE,
    CMD_REMOVE
  } cmd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // Running result of one pass along the cell chain.
  typedef struct packed {
    logic                hit;
    logic [IDX_W-1:0]    hit_idx;
    logic                free_ok;
    logic [IDX_W-1:0]    free_idx;
    logic [USED_W-1:0]   used;
    logic                vic_ok;
    logic [IDX_W-1:0]    vic_idx;
    logic [KEY_W-1:0]    vic_key;
    logic [CNT_W-1:0]    vic_cnt;
    logic [TIME_W-1:0]   vic_time;
  } tok_t;

  // Update broadcast to every cell at the end of an operation.
  typedef struct packed {
    cmd_op_t             op;
    logic [IDX_W-1:0]    idx;
    logic [KEY_W-1:0]    key;
    logic [TIME_W-1:0]   stamp;
  } cmd_t;

endpackage

[src/lfu_cell.sv]
// One table slot of the LFU chain: holds an entry and merges it into the passing scan beat.
// Depends on lfu_pkg.
module lfu_cell import lfu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  logic [KEY_W-1:0] key,
  input  tok_t             tok_i,
  output tok_t             tok_o,
  input  cmd_t             cmd
);

  logic              valid_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] ins_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] fut_r;

  tok_t              tok_r;
  tok_t              tok_nxt;
  logic [TIME_W-1:0] eff_time;
  logic              mine;
  logic [CNT_W-1:0]  cnt_inc;

  // At count zero the insert time breaks ties, otherwise the first-use time.
  assign eff_time = (cnt_r == '0) ? ins_r : fut_r;

  always_comb begin
    tok_nxt = tok_i;
    if (valid_r && key_r == key) begin
      tok_nxt.hit     = 1'b1;
      tok_nxt.hit_idx = cell_idx;
    end
    if (!valid_r && !tok_i.free_ok) begin
      tok_nxt.free_ok  = 1'b1;
      tok_nxt.free_idx = cell_idx;
    end
    if (valid_r) begin
      tok_nxt.used = tok_i.used + USED_W'(1);
    end
    if (valid_r && (!tok_i.vic_ok || cnt_r < tok_i.vic_cnt ||
                    (cnt_r == tok_i.vic_cnt && eff_time < tok_i.vic_time))) begin
      tok_nxt.vic_ok   = 1'b1;
      tok_nxt.vic_idx  = cell_idx;
      tok_nxt.vic_key  = key_r;
      tok_nxt.vic_cnt  = cnt_r;
      tok_nxt.vic_time = eff_time;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_o = tok_r;

  assign mine    = (cmd.idx == cell_idx);
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (mine && cmd.op == CMD_INSERT) begin
      valid_r <= 1'b1;
    end else if (mine && cmd.op == CMD_REMOVE) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mine && cmd.op == CMD_INSERT) begin
      key_r <= cmd.key;
      ins_r <= cmd.stamp;
      cnt_r <= '0;
      fut_r <= '0;
    end else if (mine && cmd.op == CMD_USE) begin
      cnt_r <= cnt_inc;
      if (cnt_r == '0) begin
        fut_r <= cmd.stamp;
      end
    end
  end

endmodule

[src/lfu_table_with_time_tiebreak.sv]
// Top level of the LFU table: control sequencer, clock counter, config register, cell chain.
// Depends on lfu_pkg and lfu_cell.
//
//   port group  | dir    | handshake            | payload
//   in_*        | input  | in_valid / in_ready  | in_func, in_key_id
//   out_*       | output | out_valid / out_ready| out_status, out_evicted, out_evicted_id
//   APB         | input  | psel/penable/pready  | paddr, pwdata, prdata
//
// An item is handled in two steps after acceptance: one scan beat walks the SLOTS cells
// one per cycle, then a decide step updates the table and registers the result.
// Items are taken one at a time, the next only after the last decide step; a waiting
// result does not block acceptance, but the decide step holds until the output is free.
// Reset clears all slot valid bits and the clock count, and sets capacity to 16.
module lfu_table_with_time_tiebreak import lfu_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [KEY_W-1:0]  in_key_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_status,
  output logic              out_evicted,
  output logic [KEY_W-1:0]  out_evicted_id,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  ctr_r, ctr_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  logic [CAP_W-1:0]  cap_r;

  logic              out_valid_r, out_valid_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_evicted_r, out_evicted_nxt;
  logic [KEY_W-1:0]  out_evicted_id_r, out_evicted_id_nxt;

  tok_t              tok [SLOTS+1];
  tok_t              tail;
  cmd_t              cmd;
  logic              fire;
  logic              full;
  logic [TIME_W-1:0] clock_adv;
  logic [USED_W-1:0] cap_ext;
  logic [USED_W-1:0] cap_eff;

  // Config port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(cap_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      cap_r <= pwdata[CAP_W-1:0];
    end
  end

  // Cell chain.
  assign tok[0] = '0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lfu_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .key      (key_r),
      .tok_i    (tok[i]),
      .tok_o    (tok[i+1]),
      .cmd      (cmd)
    );
  end

  assign tail = tok[SLOTS];

  assign in_ready = (state_r == ST_IDLE);
  assign fire     = (state_r == ST_COMMIT) && (!out_valid_r || out_ready);

  assign clock_adv = (clock_r == TIME_MAX) ? clock_r : clock_r + TIME_W'(1);
  assign cap_ext   = USED_W'(cap_r);
  assign cap_eff   = (cap_ext == '0) ? USED_W'(1) :
                     (cap_ext > USED_W'(SLOTS)) ? USED_W'(SLOTS) : cap_ext;
  assign full      = (tail.used >= cap_eff) || !tail.free_ok;

  always_comb begin
    state_nxt          = state_r;
    ctr_nxt            = ctr_r;
    clock_nxt          = clock_r;
    out_valid_nxt      = out_valid_r && !out_ready;
    out_status_nxt     = out_status_r;
    out_evicted_nxt    = out_evicted_r;
    out_evicted_id_nxt = out_evicted_id_r;
    cmd.op             = CMD_NONE;
    cmd.idx            = tail.hit_idx;
    cmd.key            = key_r;
    cmd.stamp          = clock_adv;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          ctr_nxt   = '0;
        end
      end
      ST_SCAN: begin
        ctr_nxt = ctr_r + IDX_W'(1);
        if (ctr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (fire) begin
          state_nxt          = ST_IDLE;
          out_valid_nxt      = 1'b1;
          out_status_nxt     = 1'b1;
          out_evicted_nxt    = 1'b0;
          out_evicted_id_nxt = '0;
          case (func_r)
            FUNC_INSERT: begin
              if (!tail.hit) begin
                clock_nxt       = clock_adv;
                out_status_nxt  = 1'b0;
                cmd.op          = CMD_INSERT;
                cmd.idx         = full ? tail.vic_idx : tail.free_idx;
                out_evicted_nxt = full;
                if (full) begin
                  out_evicted_id_nxt = tail.vic_key;
                end
              end
            end
            FUNC_USE: begin
              clock_nxt      = clock_adv;
              out_status_nxt = !tail.hit;
              if (tail.hit) begin
                cmd.op = CMD_USE;
              end
            end
            FUNC_REMOVE: begin
              clock_nxt      = clock_adv;
              out_status_nxt = !tail.hit;
              if (tail.hit) begin
                cmd.op = CMD_REMOVE;
              end
            end
            default: begin
              out_status_nxt = 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ctr_r       <= '0;
      clock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctr_r       <= ctr_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_r <= in_func;
      key_r  <= in_key_id;
    end
    out_status_r     <= out_status_nxt;
    out_evicted_r    <= out_evicted_nxt;
    out_evicted_id_r <= out_evicted_id_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_evicted    = out_evicted_r;
  assign out_evicted_id = out_evicted_id_r;

endmodule

[src/lfu_chk.sv]
// Port-level checker for the LFU table, bound to the top level.
// Depends on lfu_pkg.
module lfu_chk import lfu_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             out_status,
  input logic             out_evicted,
  input logic [KEY_W-1:0] out_evicted_id,
  input logic             pready
);

  // Only a successful insert can evict.
  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_evicted |-> !out_status)
    else $error("eviction reported on a failed operation");

  // Without an eviction the reported key is zero.
  a_evict_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted |-> out_evicted_id == '0)
    else $error("evicted key nonzero without eviction");

  // One item at a time: an accepted beat makes the input side busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
                                $stable(out_evicted) && $stable(out_evicted_id))
    else $error("result changed while stalled");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind lfu_table_with_time_tiebreak lfu_chk u_lfu_chk (.*);
